// ===== design/ncc_pkg.sv =====
// shared types, constants and arctangent table for the collinearity check
`timescale 1ns / 1ps
package ncc_pkg;

  localparam int COORD_BITS = 24;
  localparam int ANGLE_BITS = 15;

  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int SUM_BITS = PROD_BITS + 2;
  localparam int SCALE_BITS = 30;
  localparam int NORM_BITS = (SUM_BITS > SCALE_BITS) ? SUM_BITS : SCALE_BITS;
  localparam int LEN_BITS = $clog2(NORM_BITS + 1);
  localparam int SQ_BITS = 2 * SCALE_BITS;
  localparam int RAD_BITS = SQ_BITS + 2;
  localparam int ROOT_BITS = RAD_BITS / 2;
  localparam int RW = RAD_BITS + 1;
  localparam int SQRT_STEPS = ROOT_BITS;
  localparam int CORDIC_STEPS = 32;
  localparam int CX_BITS = ROOT_BITS + 10 + 5;
  localparam int ACC_BITS = 34;
  localparam int OUT_SHIFT = 31 - ANGLE_BITS;

  localparam logic signed [ACC_BITS-1:0] PI_UNITS = ACC_BITS'(64'd1 << 31);
  localparam logic signed [ACC_BITS-1:0] HALF_PI_UNITS = ACC_BITS'(64'd1 << 30);
  localparam logic [32:0] OUT_HALF = 33'(64'd1 << (30 - ANGLE_BITS));
  localparam logic [ANGLE_BITS:0] FULL_ANGLE = (ANGLE_BITS+1)'(64'd1 << ANGLE_BITS);
  localparam logic [ANGLE_BITS:0] HALF_ANGLE = (ANGLE_BITS+1)'(64'd1 << (ANGLE_BITS - 1));

  typedef struct packed {
    logic                         is_3d;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p1_z;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p2_z;
    logic signed [COORD_BITS-1:0] p3_x;
    logic signed [COORD_BITS-1:0] p3_y;
    logic signed [COORD_BITS-1:0] p3_z;
  } operands_t;

  typedef struct packed {
    logic [ANGLE_BITS:0]   raw_angle;
    logic [ANGLE_BITS-1:0] folded_angle;
    logic                  collinear;
    logic                  degenerate;
  } result_t;

  typedef struct packed {
    logic                  valid;
    logic                  degen;
    logic                  dneg;
    logic [SCALE_BITS-1:0] sd;
  } sqrt_side_t;

  typedef struct packed {
    logic valid;
    logic degen;
    logic bypass;
  } cordic_side_t;

  function automatic logic [29:0] atan_entry(input logic [4:0] k);
    logic [29:0] v;
    case (k)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000029;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      5'd30: v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== design/ncc_front.sv =====
// front pipeline: differences, cross and dot products, normalization, sum of squares
`timescale 1ns / 1ps
module ncc_front
  import ncc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  operands_t           operands,
  output sqrt_side_t          side,
  output logic [RAD_BITS-1:0] rad
);

  logic v1, v2, v3, v4, v5, v6, v7;
  logic d2, d3, d4, d5, d6, d7;
  logic n4, n5, n6, n7;
  logic [SCALE_BITS-1:0] sd7;

  logic signed [DIFF_BITS-1:0] ax, ay, az, bx, by, bz;
  logic signed [PROD_BITS-1:0] m_yz, m_zy, m_zx, m_xz, m_xy, m_yx, m_xx, m_yy, m_zz;
  logic signed [SUM_BITS-1:0] cx, cy, cz, dt;
  logic [NORM_BITS-1:0] mx, my, mz, md;
  logic [NORM_BITS-1:0] mx5, my5, mz5, md5;
  logic [LEN_BITS-1:0] sh5;
  logic [SCALE_BITS-1:0] sx, sy, sz, sd;
  logic [SQ_BITS-1:0] qx, qy, qz;

  logic [NORM_BITS-1:0] all_or;
  logic [LEN_BITS-1:0] sh_next;
  logic [NORM_BITS-1:0] tx, ty, tz, td;

  function automatic logic [NORM_BITS-1:0] mag(input logic signed [SUM_BITS-1:0] v);
    logic [SUM_BITS-1:0] m;
    m = v[SUM_BITS-1] ? $unsigned(-v) : $unsigned(v);
    return NORM_BITS'(m);
  endfunction

  always_comb begin
    all_or = mx | my | mz | md;
    sh_next = '0;
    for (int i = 0; i < NORM_BITS; i++) begin
      if (all_or[i]) begin
        sh_next = LEN_BITS'(NORM_BITS - 1 - i);
      end
    end
    tx = mx5 << sh5;
    ty = my5 << sh5;
    tz = mz5 << sh5;
    td = md5 << sh5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else begin
      side.valid <= v7;
    end

    ax <= DIFF_BITS'(operands.p2_x) - DIFF_BITS'(operands.p1_x);
    ay <= DIFF_BITS'(operands.p2_y) - DIFF_BITS'(operands.p1_y);
    bx <= DIFF_BITS'(operands.p3_x) - DIFF_BITS'(operands.p1_x);
    by <= DIFF_BITS'(operands.p3_y) - DIFF_BITS'(operands.p1_y);
    if (operands.is_3d) begin
      az <= DIFF_BITS'(operands.p2_z) - DIFF_BITS'(operands.p1_z);
      bz <= DIFF_BITS'(operands.p3_z) - DIFF_BITS'(operands.p1_z);
    end else begin
      az <= '0;
      bz <= '0;
    end

    m_yz <= ay * bz;
    m_zy <= az * by;
    m_zx <= az * bx;
    m_xz <= ax * bz;
    m_xy <= ax * by;
    m_yx <= ay * bx;
    m_xx <= ax * bx;
    m_yy <= ay * by;
    m_zz <= az * bz;
    d2 <= (ax == '0 && ay == '0 && az == '0) || (bx == '0 && by == '0 && bz == '0);

    cx <= SUM_BITS'(m_yz) - SUM_BITS'(m_zy);
    cy <= SUM_BITS'(m_zx) - SUM_BITS'(m_xz);
    cz <= SUM_BITS'(m_xy) - SUM_BITS'(m_yx);
    dt <= SUM_BITS'(m_xx) + SUM_BITS'(m_yy) + SUM_BITS'(m_zz);
    d3 <= d2;

    mx <= mag(cx);
    my <= mag(cy);
    mz <= mag(cz);
    md <= mag(dt);
    n4 <= dt[SUM_BITS-1];
    d4 <= d3;

    mx5 <= mx;
    my5 <= my;
    mz5 <= mz;
    md5 <= md;
    sh5 <= sh_next;
    n5 <= n4;
    d5 <= d4;

    sx <= tx[NORM_BITS-1 -: SCALE_BITS];
    sy <= ty[NORM_BITS-1 -: SCALE_BITS];
    sz <= tz[NORM_BITS-1 -: SCALE_BITS];
    sd <= td[NORM_BITS-1 -: SCALE_BITS];
    n6 <= n5;
    d6 <= d5;

    qx <= sx * sx;
    qy <= sy * sy;
    qz <= sz * sz;
    sd7 <= sd;
    n7 <= n6;
    d7 <= d6;

    rad <= RAD_BITS'(qx) + RAD_BITS'(qy) + RAD_BITS'(qz);
    side.degen <= d7;
    side.dneg <= n7;
    side.sd <= sd7;
  end

endmodule

// ===== design/ncc_sqrt_cell.sv =====
// one digit of the integer square root chain
`timescale 1ns / 1ps
module ncc_sqrt_cell
  import ncc_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  sqrt_side_t          side_in,
  input  logic [RAD_BITS-1:0] rem_in,
  input  logic [RW-1:0]       root_in,
  output sqrt_side_t          side_out,
  output logic [RAD_BITS-1:0] rem_out,
  output logic [RW-1:0]       root_out
);

  localparam logic [RW-1:0] BIT = RW'(1) << (2 * STEP);

  logic [RW-1:0] trial;
  logic [RW-1:0] rem_wide;

  always_comb begin
    trial = root_in + BIT;
    rem_wide = RW'(rem_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= side_in.valid;
    end
    side_out.degen <= side_in.degen;
    side_out.dneg <= side_in.dneg;
    side_out.sd <= side_in.sd;
    if (rem_wide >= trial) begin
      rem_out <= RAD_BITS'(rem_wide - trial);
      root_out <= (root_in >> 1) + BIT;
    end else begin
      rem_out <= rem_in;
      root_out <= root_in >> 1;
    end
  end

endmodule

// ===== design/ncc_cordic_cell.sv =====
// one vectoring rotation of the angle chain
`timescale 1ns / 1ps
module ncc_cordic_cell
  import ncc_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cordic_side_t               side_in,
  input  logic signed [CX_BITS-1:0]  x_in,
  input  logic signed [CX_BITS-1:0]  y_in,
  input  logic signed [ACC_BITS-1:0] acc_in,
  output cordic_side_t               side_out,
  output logic signed [CX_BITS-1:0]  x_out,
  output logic signed [CX_BITS-1:0]  y_out,
  output logic signed [ACC_BITS-1:0] acc_out
);

  localparam logic signed [ACC_BITS-1:0] ANGLE = ACC_BITS'(atan_entry(5'(STEP)));

  logic signed [CX_BITS-1:0] dx, dy;

  always_comb begin
    dx = y_in >>> STEP;
    dy = x_in >>> STEP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= side_in.valid;
    end
    side_out.degen <= side_in.degen;
    side_out.bypass <= side_in.bypass;
    if (side_in.bypass) begin
      x_out <= x_in;
      y_out <= y_in;
      acc_out <= acc_in;
    end else if (y_in > 0) begin
      x_out <= x_in + dx;
      y_out <= y_in - dy;
      acc_out <= acc_in + ANGLE;
    end else begin
      x_out <= x_in - dx;
      y_out <= y_in + dy;
      acc_out <= acc_in - ANGLE;
    end
  end

endmodule

// ===== design/near_collinearity_check_top.sv =====
// near-collinearity check: angle between two difference vectors of three points
// path from start to done: 8 front stages, 31 root cells,
// one setup stage, 32 rotation cells and the output register
// throughput one transaction per cycle, busy stays low, done pulses one cycle
// synchronous reset clears the pipeline valid bits and the tolerance register
`timescale 1ns / 1ps
module near_collinearity_check_top
  import ncc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  operands_t             operands,
  output logic                  done,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [ANGLE_BITS-1:0] cfg_wdata
);

  logic [ANGLE_BITS-1:0] tolerance;

  sqrt_side_t          sq_side [0:SQRT_STEPS];
  logic [RAD_BITS-1:0] sq_rem  [0:SQRT_STEPS];
  logic [RW-1:0]       sq_root [0:SQRT_STEPS];

  cordic_side_t               co_side [0:CORDIC_STEPS];
  logic signed [CX_BITS-1:0]  co_x    [0:CORDIC_STEPS];
  logic signed [CX_BITS-1:0]  co_y    [0:CORDIC_STEPS];
  logic signed [ACC_BITS-1:0] co_acc  [0:CORDIC_STEPS];

  logic [ROOT_BITS-1:0] s;
  logic [CX_BITS-1:0] s_scaled, d_scaled;
  sqrt_side_t last;
  cordic_side_t fin;
  logic signed [ACC_BITS-1:0] acc_f;
  logic [32:0] clamped, rounded;
  logic [ANGLE_BITS:0] raw, folded_w;
  result_t result_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  ncc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .operands (operands),
    .side     (sq_side[0]),
    .rad      (sq_rem[0])
  );

  assign sq_root[0] = '0;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    ncc_sqrt_cell #(.STEP(SQRT_STEPS - 1 - i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .side_in  (sq_side[i]),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .side_out (sq_side[i+1]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1])
    );
  end

  // setup of the rotation chain
  always_comb begin
    last = sq_side[SQRT_STEPS];
    s = sq_root[SQRT_STEPS][ROOT_BITS-1:0];
    s_scaled = CX_BITS'({s, 10'b0});
    d_scaled = CX_BITS'({last.sd, 10'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      co_side[0].valid <= 1'b0;
    end else begin
      co_side[0].valid <= last.valid;
    end
    co_side[0].degen <= last.degen;
    co_side[0].bypass <= (s == '0) || (last.sd == '0);
    if (s == '0) begin
      co_acc[0] <= last.dneg ? PI_UNITS : '0;
    end else if (last.sd == '0 || last.dneg) begin
      co_acc[0] <= HALF_PI_UNITS;
    end else begin
      co_acc[0] <= '0;
    end
    if (last.dneg) begin
      co_x[0] <= $signed(s_scaled);
      co_y[0] <= $signed(d_scaled);
    end else begin
      co_x[0] <= $signed(d_scaled);
      co_y[0] <= $signed(s_scaled);
    end
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    ncc_cordic_cell #(.STEP(j)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .side_in  (co_side[j]),
      .x_in     (co_x[j]),
      .y_in     (co_y[j]),
      .acc_in   (co_acc[j]),
      .side_out (co_side[j+1]),
      .x_out    (co_x[j+1]),
      .y_out    (co_y[j+1]),
      .acc_out  (co_acc[j+1])
    );
  end

  // clamp, round and fold
  always_comb begin
    fin = co_side[CORDIC_STEPS];
    acc_f = co_acc[CORDIC_STEPS];
    if (acc_f < 0) begin
      clamped = '0;
    end else if (acc_f > PI_UNITS) begin
      clamped = 33'(PI_UNITS);
    end else begin
      clamped = 33'(acc_f);
    end
    rounded = (clamped + OUT_HALF) >> OUT_SHIFT;
    raw = (rounded > 33'(FULL_ANGLE)) ? FULL_ANGLE : rounded[ANGLE_BITS:0];
    folded_w = (raw > HALF_ANGLE) ? (FULL_ANGLE - raw) : raw;
    if (fin.degen) begin
      result_next = '0;
      result_next.degenerate = 1'b1;
    end else begin
      result_next.raw_angle = raw;
      result_next.folded_angle = folded_w[ANGLE_BITS-1:0];
      result_next.collinear = folded_w[ANGLE_BITS-1:0] <= tolerance;
      result_next.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the near-collinearity check pipeline
`timescale 1ns / 1ps
module tb
  import ncc_pkg::*;
();

  localparam int DRAIN_CYCLES = 90;
  localparam logic [ANGLE_BITS-1:0] TOL_RIGHT = 15'd16384;
  localparam logic [ANGLE_BITS-1:0] TOL_TOP = 15'h7fff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  operands_t operands = '0;
  logic done;
  result_t result;
  logic cfg_we = 1'b0;
  logic [ANGLE_BITS-1:0] cfg_wdata = '0;

  result_t expected_q[$];
  logic [ANGLE_BITS-1:0] tolerance = '0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;

  longint atan_steps[32] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001, 64'h00000000};

  near_collinearity_check_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operands(operands),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned to_30_bits(input logic [127:0] m, input int len);
    if (len > 30) return 64'(m >> (len - 30));
    return 64'(m << (30 - len));
  endfunction

  function automatic result_t predict_angle(input operands_t op,
                                            input logic [ANGLE_BITS-1:0] tol);
    result_t r;
    longint a[3];
    longint b[3];
    logic signed [127:0] sa[3];
    logic signed [127:0] sb[3];
    logic signed [127:0] cx, cy, cz, dt;
    logic [127:0] mx, my, mz, md, all;
    int len;
    longint unsigned sx, sy, sz, sd, s;
    longint x, y, dx, dy, acc;
    longint unsigned raw, folded;
    a[0] = longint'(op.p2_x) - longint'(op.p1_x);
    a[1] = longint'(op.p2_y) - longint'(op.p1_y);
    b[0] = longint'(op.p3_x) - longint'(op.p1_x);
    b[1] = longint'(op.p3_y) - longint'(op.p1_y);
    a[2] = op.is_3d ? longint'(op.p2_z) - longint'(op.p1_z) : 0;
    b[2] = op.is_3d ? longint'(op.p3_z) - longint'(op.p1_z) : 0;
    r = '0;
    if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
      r.degenerate = 1'b1;
      return r;
    end
    for (int k = 0; k < 3; k++) begin
      sa[k] = a[k];
      sb[k] = b[k];
    end
    cx = sa[1] * sb[2] - sa[2] * sb[1];
    cy = sa[2] * sb[0] - sa[0] * sb[2];
    cz = sa[0] * sb[1] - sa[1] * sb[0];
    dt = sa[0] * sb[0] + sa[1] * sb[1] + sa[2] * sb[2];
    mx = cx < 0 ? -cx : cx;
    my = cy < 0 ? -cy : cy;
    mz = cz < 0 ? -cz : cz;
    md = dt < 0 ? -dt : dt;
    all = mx | my | mz | md;
    len = 0;
    for (int i = 0; i < 128; i++) if (all[i]) len = i + 1;
    sx = to_30_bits(mx, len);
    sy = to_30_bits(my, len);
    sz = to_30_bits(mz, len);
    sd = to_30_bits(md, len);
    s = int_sqrt(sx * sx + sy * sy + sz * sz);
    if (s == 0) begin
      acc = (dt < 0) ? (64'sd1 << 31) : 0;
    end else if (sd == 0) begin
      acc = 64'sd1 << 30;
    end else begin
      if (dt < 0) begin
        x = s;
        y = sd;
        acc = 64'sd1 << 30;
      end else begin
        x = sd;
        y = s;
        acc = 0;
      end
      x = x * 1024;
      y = y * 1024;
      for (int k = 0; k < 32; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (y > 0) begin
          x = x + dx;
          y = y - dy;
          acc = acc + atan_steps[k];
        end else begin
          x = x - dx;
          y = y + dy;
          acc = acc - atan_steps[k];
        end
      end
      if (acc < 0) acc = 0;
      if (acc > (64'sd1 << 31)) acc = 64'sd1 << 31;
    end
    raw = (acc + (64'sd1 << (30 - ANGLE_BITS))) >>> (31 - ANGLE_BITS);
    if (raw > (64'd1 << ANGLE_BITS)) raw = 64'd1 << ANGLE_BITS;
    folded = (raw > (64'd1 << (ANGLE_BITS - 1))) ? (64'd1 << ANGLE_BITS) - raw : raw;
    r.raw_angle = raw[ANGLE_BITS:0];
    r.folded_angle = folded[ANGLE_BITS-1:0];
    r.collinear = (folded <= tol);
    return r;
  endfunction

  // compare every transaction against the oldest expectation
  always @(posedge clk) begin
    result_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result raw_angle %0d", result.raw_angle);
        errors++;
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (result.raw_angle !== e.raw_angle) begin
          $error("raw_angle expected %0d actual %0d", e.raw_angle, result.raw_angle);
          errors++;
        end
        if (result.folded_angle !== e.folded_angle) begin
          $error("folded_angle expected %0d actual %0d", e.folded_angle, result.folded_angle);
          errors++;
        end
        if (result.collinear !== e.collinear) begin
          $error("collinear expected %0b actual %0b", e.collinear, result.collinear);
          errors++;
        end
        if (result.degenerate !== e.degenerate) begin
          $error("degenerate expected %0b actual %0b", e.degenerate, result.degenerate);
          errors++;
        end
      end
    end
  end

  task automatic send_triple(input operands_t op);
    operands <= op;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_angle(op, tolerance));
    n_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [ANGLE_BITS-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tolerance = value;
  endtask

  function automatic operands_t make_triple(input logic d3,
      input longint x1, input longint y1, input longint z1,
      input longint x2, input longint y2, input longint z2,
      input longint x3, input longint y3, input longint z3);
    operands_t op;
    op.is_3d = d3;
    op.p1_x = x1[23:0]; op.p1_y = y1[23:0]; op.p1_z = z1[23:0];
    op.p2_x = x2[23:0]; op.p2_y = y2[23:0]; op.p2_z = z2[23:0];
    op.p3_x = x3[23:0]; op.p3_y = y3[23:0]; op.p3_z = z3[23:0];
    return op;
  endfunction

  function automatic longint rand_span(input int span);
    return longint'($urandom_range(2 * span)) - span;
  endfunction

  function automatic operands_t random_triple();
    operands_t op;
    longint v[3];
    longint w[3];
    longint p[3];
    longint k;
    int kind;
    kind = $urandom_range(9);
    op = ($bits(operands_t))'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom});
    if (kind < 2) return op;
    for (int i = 0; i < 3; i++) begin
      p[i] = rand_span(1 << 20);
      v[i] = rand_span(kind < 5 ? 1024 : 8);
      w[i] = rand_span(kind == 9 ? 8 : 2);
    end
    k = rand_span(60);
    if (kind == 8) k = 0;
    return make_triple(op.is_3d, p[0], p[1], p[2],
                       p[0] + v[0], p[1] + v[1], p[2] + v[2],
                       p[0] + k * v[0] + w[0], p[1] + k * v[1] + w[1],
                       p[2] + k * v[2] + w[2]);
  endfunction

  task automatic test_directed();
    longint lo;
    longint hi;
    lo = -8388608;
    hi = 8388607;
    send_triple(make_triple(1'b1, 0, 0, 0, 0, 0, 0, 5, 5, 5));
    send_triple(make_triple(1'b1, 3, 4, 5, 9, 9, 9, 3, 4, 5));
    send_triple(make_triple(1'b0, 1, 1, 7, 1, 1, -7, 4, 4, 100));
    send_triple(make_triple(1'b0, 0, 0, 0, 10, 0, 0, 20, 0, 0));
    send_triple(make_triple(1'b0, 0, 0, 0, 10, 0, 0, -20, 0, 0));
    send_triple(make_triple(1'b0, 0, 0, 0, 10, 0, 0, 0, 33, 0));
    send_triple(make_triple(1'b1, 0, 0, 0, 0, 0, 1, 0, 1, 0));
    send_triple(make_triple(1'b1, 0, 0, 0, 1, 1, 1, 2, 2, 2));
    send_triple(make_triple(1'b0, 0, 0, lo, 1, 0, hi, 1, 1, 0));
    send_triple(make_triple(1'b1, lo, lo, lo, hi, hi, hi, hi, lo, hi));
    send_triple(make_triple(1'b1, hi, hi, hi, lo, lo, lo, lo, lo, hi));
    send_triple(make_triple(1'b1, lo, hi, lo, hi, lo, hi, lo, lo, lo));
    send_triple(make_triple(1'b0, hi, lo, 0, lo, hi, 0, hi, hi, 0));
    send_triple(make_triple(1'b0, 0, 0, 0, hi, 1, 0, hi, 0, 0));
    send_triple(make_triple(1'b0, 0, 0, 0, hi, 1, 0, lo, 0, 0));
    send_triple(make_triple(1'b0, 0, 0, 0, 1000, 1, 0, 1000, 0, 0));
    send_triple(make_triple(1'b0, 0, 0, 0, 1, 1, 0, -1, 0, 0));
    send_triple(make_triple(1'b1, -1, -1, -1, 0, -1, -1, -1, 0, 0));
    send_triple(make_triple(1'b0, 0, 0, 0, 2, 1, 0, -4, -2, 0));
    send_triple(make_triple(1'b1, 5, 5, 5, 5, 5, 6, 5, 5, 4));
  endtask

  task automatic test_tolerances();
    logic [ANGLE_BITS-1:0] setting[6];
    setting = '{15'd0, 15'd1, 15'd200, TOL_RIGHT, TOL_TOP, 15'h2aaa};
    foreach (setting[i]) begin
      write_tolerance(setting[i]);
      for (int j = 0; j < 15; j++) send_triple(random_triple());
      send_triple(make_triple(1'b0, 0, 0, 0, 10, 0, 0, 0, 10, 0));
      send_triple(make_triple(1'b0, 0, 0, 0, 0, 0, 0, 1, 1, 0));
    end
  endtask

  task automatic test_random_bursts();
    int burst;
    int left;
    left = 520;
    while (left > 0) begin
      if ($urandom_range(7) == 0) write_tolerance(ANGLE_BITS'($urandom_range(17000)));
      burst = $urandom_range(40, 1);
      for (int j = 0; j < burst && left > 0; j++) begin
        send_triple(random_triple());
        left--;
      end
      if ($urandom_range(9) == 0) wait_drained();
      else if ($urandom_range(3) != 0) pause_sender($urandom_range(12, 1));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_tolerances();
    test_random_bursts();
    wait_drained();
    $display("covered %0d triples, %0d results checked, tolerance from 0 to full scale",
             n_sent, n_checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
